// ===== rtl/mcs_pkg.sv =====
// Shared types, constants and helper functions of the metronome click scheduler.
package mcs_pkg;

	localparam int FRAME_COUNT_BITS = 48;
	localparam int CLICK_ADDR_BITS  = 12;

	// Width wide enough for both the click length register and a template address.
	localparam int LEN_CMP_BITS = (CLICK_ADDR_BITS > 12) ? CLICK_ADDR_BITS : 12;
	localparam int CLICK_LIM    = (2 ** CLICK_ADDR_BITS) - 1;

	localparam logic [11:0] CLICK_LENGTH_RESET = 12'd480;

	// Register map: one register, index 0.
	localparam int          PADDR_BITS       = 3;
	localparam logic        REG_CLICK_LENGTH = 1'b0;

	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_ARM  = 2'd1;
	localparam logic [1:0] CMD_STOP = 2'd2;

	localparam logic [1:0] MODE_IDLE      = 2'd0;
	localparam logic [1:0] MODE_ARMED     = 2'd1;
	localparam logic [1:0] MODE_RECORDING = 2'd2;

	typedef logic [FRAME_COUNT_BITS-1:0] frame_t;

	typedef struct packed {
		logic [1:0]         command;
		logic [19:0]        beat_interval;
		logic [7:0]         beats_per_bar;
		logic [7:0]         count_in_beats;
		logic [19:0]        pre_roll_frames;
		logic signed [15:0] mic_sample;
	} item_t;

	typedef struct packed {
		logic [1:0]         run_mode;
		logic               click_on;
		logic               click_is_downbeat;
		logic [11:0]        click_address;
		logic               record_strobe;
		logic signed [15:0] record_sample;
		logic [7:0]         count_in_left;
		logic [31:0]        recorded_frames;
	} result_t;

	// a >= b on the wrapping frame counter.
	function automatic logic serial_ge(frame_t a, frame_t b);
		frame_t d;
		d = a - b;
		return ~d[FRAME_COUNT_BITS-1];
	endfunction

	// Template length actually used, limited to what the address counter can reach.
	function automatic logic [CLICK_ADDR_BITS-1:0] click_len_eff(logic [11:0] cl);
		logic [LEN_CMP_BITS-1:0] w;
		w = LEN_CMP_BITS'(cl);
		if (w > LEN_CMP_BITS'(CLICK_LIM))
			return CLICK_ADDR_BITS'(CLICK_LIM);
		else
			return CLICK_ADDR_BITS'(w);
	endfunction

endpackage

// ===== rtl/mcs_regs.sv =====
// APB register block holding the click template length.
module mcs_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mcs_pkg::PADDR_BITS-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output logic [11:0]                    click_length
);

	logic [11:0] click_length_q;
	logic        sel_len;

	assign sel_len = (paddr[2] == mcs_pkg::REG_CLICK_LENGTH);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			click_length_q <= mcs_pkg::CLICK_LENGTH_RESET;
		end else if (psel && penable && pwrite && sel_len) begin
			click_length_q <= pwdata[11:0];
		end
	end

	assign prdata       = sel_len ? {20'd0, click_length_q} : 32'd0;
	assign click_length = click_length_q;

endmodule

// ===== rtl/mcs_engine.sv =====
// Scheduler state and the one-pass update that turns one item into one result.
module mcs_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  mcs_pkg::item_t      item,
	input  logic [11:0]         click_length,
	output mcs_pkg::result_t    result
);

	localparam int FCB = mcs_pkg::FRAME_COUNT_BITS;
	localparam int CAB = mcs_pkg::CLICK_ADDR_BITS;
	localparam int LW  = mcs_pkg::LEN_CMP_BITS;

	logic [1:0]          run_q;
	mcs_pkg::frame_t     frame_q;
	mcs_pkg::frame_t     next_click_q;
	mcs_pkg::frame_t     downbeat_q;
	mcs_pkg::frame_t     pre_start_q;
	logic [19:0]         interval_q;
	logic [7:0]          bar_q;
	logic [7:0]          beat_q;
	logic                busy_q;
	logic                sel_q;
	logic [CAB-1:0]      pos_q;
	logic [7:0]          count_in_q;
	logic [31:0]         rec_q;

	logic [1:0]          run_n;
	mcs_pkg::frame_t     frame_n;
	mcs_pkg::frame_t     next_click_n;
	mcs_pkg::frame_t     downbeat_n;
	mcs_pkg::frame_t     pre_start_n;
	logic [19:0]         interval_n;
	logic [7:0]          bar_n;
	logic [7:0]          beat_n;
	logic                busy_n;
	logic                sel_n;
	logic [CAB-1:0]      pos_n;
	logic [7:0]          count_in_n;
	logic [31:0]         rec_n;

	logic [CAB-1:0]      len;
	logic [CAB-1:0]      pos_inc;
	logic [19:0]         iv_arm;
	logic [27:0]         prod;
	logic [28:0]         pre_off;
	mcs_pkg::frame_t     click_step;
	mcs_pkg::frame_t     lag;
	logic [8:0]          beat_inc;
	logic                on;
	logic                dn;
	logic [CAB-1:0]      addr;
	logic                strobe;
	logic [LW-1:0]       addr_w;

	assign len     = mcs_pkg::click_len_eff(click_length);
	assign pos_inc = pos_q + CAB'(1);

	// Arm arithmetic: count-in span and pre-roll offset relative to the current frame.
	assign iv_arm  = (item.beat_interval == 20'd0) ? 20'd1 : item.beat_interval;
	assign prod    = 28'(item.count_in_beats) * 28'(iv_arm);
	assign pre_off = {1'b0, prod} - {9'd0, item.pre_roll_frames};

	assign click_step = next_click_q + FCB'(interval_q);
	assign lag        = frame_q - click_step;
	assign beat_inc   = {1'b0, beat_q} + 9'd1;

	always_comb begin
		run_n        = run_q;
		frame_n      = frame_q;
		next_click_n = next_click_q;
		downbeat_n   = downbeat_q;
		pre_start_n  = pre_start_q;
		interval_n   = interval_q;
		bar_n        = bar_q;
		beat_n       = beat_q;
		busy_n       = busy_q;
		sel_n        = sel_q;
		pos_n        = pos_q;
		count_in_n   = count_in_q;
		rec_n        = rec_q;
		on           = 1'b0;
		dn           = 1'b0;
		addr         = '0;
		strobe       = 1'b0;
		unique case (item.command)
			mcs_pkg::CMD_ARM: begin
				interval_n   = iv_arm;
				bar_n        = (item.beats_per_bar == 8'd0) ? 8'd1 : item.beats_per_bar;
				count_in_n   = item.count_in_beats;
				rec_n        = 32'd0;
				downbeat_n   = frame_q + FCB'(prod);
				pre_start_n  = frame_q + {{(FCB-29){pre_off[28]}}, pre_off};
				next_click_n = frame_q;
				beat_n       = 8'd0;
				busy_n       = 1'b0;
				sel_n        = 1'b0;
				pos_n        = '0;
				run_n        = mcs_pkg::MODE_ARMED;
			end
			mcs_pkg::CMD_STOP: begin
				run_n      = mcs_pkg::MODE_IDLE;
				count_in_n = 8'd0;
			end
			mcs_pkg::CMD_TICK: begin
				if (run_q == mcs_pkg::MODE_ARMED && mcs_pkg::serial_ge(frame_q, downbeat_q)) begin
					run_n      = mcs_pkg::MODE_RECORDING;
					count_in_n = 8'd0;
				end
				if (run_n == mcs_pkg::MODE_RECORDING ||
					(run_n == mcs_pkg::MODE_ARMED && mcs_pkg::serial_ge(frame_q, pre_start_q))) begin
					strobe = 1'b1;
					if (rec_q != 32'hFFFF_FFFF)
						rec_n = rec_q + 32'd1;
				end
				if (run_n == mcs_pkg::MODE_ARMED || run_n == mcs_pkg::MODE_RECORDING) begin
					// Continue the click in progress, or end it if the length shrank.
					if (busy_q) begin
						if (pos_q < len) begin
							on   = 1'b1;
							dn   = sel_q;
							addr = pos_q;
							if (pos_inc >= len) begin
								busy_n = 1'b0;
								pos_n  = '0;
							end else begin
								pos_n = pos_inc;
							end
						end else begin
							busy_n = 1'b0;
							pos_n  = '0;
						end
					end
					// Start a due click once the previous one is out of the way.
					if (!on && !busy_n && mcs_pkg::serial_ge(frame_q, next_click_q)) begin
						sel_n = (beat_q == 8'd0);
						if (len != '0) begin
							on   = 1'b1;
							dn   = sel_n;
							addr = '0;
							if (len > CAB'(1)) begin
								busy_n = 1'b1;
								pos_n  = CAB'(1);
							end
						end
						if (run_n == mcs_pkg::MODE_ARMED && count_in_q != 8'd0)
							count_in_n = count_in_q - 8'd1;
						beat_n = (beat_inc >= {1'b0, bar_q}) ? 8'd0 : beat_inc[7:0];
						if (!lag[FCB-1] && lag > (FCB'(1) << (FCB - 2)))
							next_click_n = frame_q;
						else
							next_click_n = click_step;
					end
				end
				frame_n = frame_q + FCB'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q        <= mcs_pkg::MODE_IDLE;
			frame_q      <= '0;
			next_click_q <= '0;
			downbeat_q   <= '0;
			pre_start_q  <= '0;
			interval_q   <= 20'd1;
			bar_q        <= 8'd1;
			beat_q       <= 8'd0;
			busy_q       <= 1'b0;
			sel_q        <= 1'b0;
			pos_q        <= '0;
			count_in_q   <= 8'd0;
			rec_q        <= 32'd0;
		end else if (fire) begin
			run_q        <= run_n;
			frame_q      <= frame_n;
			next_click_q <= next_click_n;
			downbeat_q   <= downbeat_n;
			pre_start_q  <= pre_start_n;
			interval_q   <= interval_n;
			bar_q        <= bar_n;
			beat_q       <= beat_n;
			busy_q       <= busy_n;
			sel_q        <= sel_n;
			pos_q        <= pos_n;
			count_in_q   <= count_in_n;
			rec_q        <= rec_n;
		end
	end

	assign addr_w = LW'(addr);

	always_comb begin
		result.run_mode          = run_n;
		result.click_on          = on;
		result.click_is_downbeat = dn;
		result.click_address     = addr_w[11:0];
		result.record_strobe     = strobe;
		result.record_sample     = strobe ? item.mic_sample : 16'sd0;
		result.count_in_left     = count_in_n;
		result.recorded_frames   = rec_n;
	end

	a_busy_pos: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pos_q != '0)
		else $error("click running at position zero");
	a_beat_range: assert property (@(posedge clk) disable iff (!arst_n)
		beat_q < bar_q)
		else $error("beat index outside the bar");
	a_grid_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		interval_q != 20'd0 && bar_q != 8'd0)
		else $error("beat grid holds a zero interval or bar length");
	a_rec_no_countin: assert property (@(posedge clk) disable iff (!arst_n)
		run_q == mcs_pkg::MODE_RECORDING |-> count_in_q == 8'd0)
		else $error("count-in left while recording");

endmodule

// ===== rtl/metronome_click_scheduler.sv =====
// Top level of the metronome click scheduler: stream ports, item and result registers.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------------
//  s_axis   | in        | tvalid / tready    | tuser command, tdata arm fields + mic
//  m_axis   | out       | tvalid / tready    | tdata one result per item
//  apb      | in        | psel/penable/pready| click_length at byte address 0
//
// One item per cycle sustained while m_axis is ready: an item is held in the input
// register and its whole update runs in one combinational pass into the result
// register. The state update (frame counter, click schedule) is the only loop and
// closes within that single pass.
// Reset clears the scheduler to idle and click_length to 480; stalls on m_axis
// hold the result register and back up into the input register.
module metronome_click_scheduler (
	input  logic                           clk,
	input  logic                           arst_n,
	// APB configuration
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mcs_pkg::PADDR_BITS-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	// Input beats
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [19:0] beat_interval, [27:20] beats_per_bar, [35:28] count_in_beats,
	// [55:36] pre_roll_frames, [71:56] mic_sample
	input  logic [71:0]                    s_axis_tdata,
	// [1:0] command
	input  logic [1:0]                     s_axis_tuser,
	// Result beats
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [1:0] run_mode, [2] click_on, [3] click_is_downbeat, [15:4] click_address,
	// [16] record_strobe, [32:17] record_sample, [40:33] count_in_left,
	// [72:41] recorded_frames, [79:73] zero
	output logic [79:0]                    m_axis_tdata
);

	logic [11:0]      click_length;
	mcs_pkg::item_t   item_s1;
	logic             valid_s1;
	mcs_pkg::result_t res_s2;
	mcs_pkg::result_t res_next;
	logic             valid_s2;
	logic             advance;

	mcs_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.click_length (click_length)
	);

	// Move the held item into the result register whenever that register is free
	// or its beat is being taken this cycle.
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Capture the input beat; payload needs no reset.
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.command         <= s_axis_tuser;
			item_s1.beat_interval   <= s_axis_tdata[19:0];
			item_s1.beats_per_bar   <= s_axis_tdata[27:20];
			item_s1.count_in_beats  <= s_axis_tdata[35:28];
			item_s1.pre_roll_frames <= s_axis_tdata[55:36];
			item_s1.mic_sample      <= s_axis_tdata[71:56];
		end
	end

	mcs_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (advance),
		.item         (item_s1),
		.click_length (click_length),
		.result       (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res_next;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {7'd0,
		res_s2.recorded_frames,
		res_s2.count_in_left,
		res_s2.record_sample,
		res_s2.record_strobe,
		res_s2.click_address,
		res_s2.click_is_downbeat,
		res_s2.click_on,
		res_s2.run_mode};

endmodule

// ===== sim/tb.sv =====
// Self-checking stream testbench for the metronome click scheduler with its own beat predictor.
`timescale 1ns / 1ps

module tb;

	// Command code that the block answers like a stop in idle.
	localparam logic [1:0] CMD_NONE = 2'd3;
	// Cycles without any beat or register access before the run is declared hung.
	localparam int STALL_LIMIT = 4000;
	// Length of the one long receiver hold-off.
	localparam int LONG_HOLD = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [mcs_pkg::PADDR_BITS-1:0] paddr = '0;
	logic [31:0]                    pwdata = '0;
	logic [31:0]                    prdata;
	logic                           pready;

	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// [19:0] beat_interval, [27:20] beats_per_bar, [35:28] count_in_beats,
	// [55:36] pre_roll_frames, [71:56] mic_sample
	logic [71:0] s_axis_tdata = '0;
	// [1:0] command
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [1:0] run_mode, [2] click_on, [3] click_is_downbeat, [15:4] click_address,
	// [16] record_strobe, [32:17] record_sample, [40:33] count_in_left,
	// [72:41] recorded_frames, [79:73] zero
	logic [79:0] m_axis_tdata;

	metronome_click_scheduler u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// Scheduler mirror: one copy of every piece of block state, at reset values.
	// ------------------------------------------------------------------
	logic [11:0]      tmpl_len = mcs_pkg::CLICK_LENGTH_RESET;
	logic [1:0]       sched_mode = mcs_pkg::MODE_IDLE;
	mcs_pkg::frame_t  frame_now = '0;
	mcs_pkg::frame_t  click_due_at = '0;
	mcs_pkg::frame_t  downbeat_frame = '0;
	mcs_pkg::frame_t  capture_from = '0;
	logic [19:0]      beat_len = 20'd1;
	logic [7:0]       bar_beats = 8'd1;
	logic [7:0]       beat_idx = '0;
	bit               clk_active = 1'b0;
	bit               clk_down = 1'b0;
	int unsigned      clk_pos = 0;
	logic [7:0]       countin_left = '0;
	logic [31:0]      take_frames = '0;

	mcs_pkg::item_t   pending_beats[$];
	mcs_pkg::result_t due_results[$];
	mcs_pkg::item_t   cur_beat;
	mcs_pkg::result_t want;

	int n_queued = 0;
	int n_sent = 0;
	int fails = 0;
	int send_idle_pct = 7;
	int recv_idle_pct = 79;
	bit long_hold_req = 1'b0;
	bit long_hold_done = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;

	// Frame times wrap; a is at or after b when the difference lies in the lower half.
	function automatic bit at_or_after(mcs_pkg::frame_t a, mcs_pkg::frame_t b);
		mcs_pkg::frame_t d;
		d = a - b;
		return !d[mcs_pkg::FRAME_COUNT_BITS-1];
	endfunction

	// Advance the mirror by one input beat and return the result beat it causes.
	function automatic mcs_pkg::result_t schedule_item(mcs_pkg::item_t b);
		mcs_pkg::result_t r;
		int unsigned      len;
		mcs_pkg::frame_t  lag;
		r = '0;
		len = (tmpl_len > mcs_pkg::CLICK_LIM) ? mcs_pkg::CLICK_LIM : tmpl_len;
		case (b.command)
			mcs_pkg::CMD_ARM: begin
				beat_len = (b.beat_interval == 0) ? 20'd1 : b.beat_interval;
				bar_beats = (b.beats_per_bar == 0) ? 8'd1 : b.beats_per_bar;
				countin_left = b.count_in_beats;
				take_frames = '0;
				downbeat_frame = frame_now + mcs_pkg::frame_t'(b.count_in_beats) *
				                 mcs_pkg::frame_t'(beat_len);
				capture_from = downbeat_frame - mcs_pkg::frame_t'(b.pre_roll_frames);
				// Grid anchored here; any click in progress is dropped.
				click_due_at = frame_now;
				beat_idx = '0;
				clk_active = 1'b0;
				clk_down = 1'b0;
				clk_pos = 0;
				sched_mode = mcs_pkg::MODE_ARMED;
			end
			mcs_pkg::CMD_STOP: begin
				sched_mode = mcs_pkg::MODE_IDLE;
				countin_left = '0;
			end
			mcs_pkg::CMD_TICK: begin
				// Recording begins exactly on the downbeat frame.
				if (sched_mode == mcs_pkg::MODE_ARMED &&
				    at_or_after(frame_now, downbeat_frame)) begin
					sched_mode = mcs_pkg::MODE_RECORDING;
					countin_left = '0;
				end
				if (sched_mode == mcs_pkg::MODE_RECORDING ||
				    (sched_mode == mcs_pkg::MODE_ARMED &&
				     at_or_after(frame_now, capture_from))) begin
					r.record_strobe = 1'b1;
					r.record_sample = b.mic_sample;
					if (take_frames != '1)
						take_frames = take_frames + 32'd1;
				end
				if (sched_mode != mcs_pkg::MODE_IDLE) begin
					// Finish a running click; a shortened template ends it silently.
					if (clk_active) begin
						if (clk_pos < len) begin
							r.click_on = 1'b1;
							r.click_is_downbeat = clk_down;
							r.click_address = 12'(clk_pos);
							clk_pos++;
							if (clk_pos >= len) begin
								clk_active = 1'b0;
								clk_pos = 0;
							end
						end else begin
							clk_active = 1'b0;
							clk_pos = 0;
						end
					end
					// A due beat starts only on a frame with no click sounding.
					if (!r.click_on && !clk_active && at_or_after(frame_now, click_due_at)) begin
						clk_down = (beat_idx == 0);
						if (len > 0) begin
							r.click_on = 1'b1;
							r.click_is_downbeat = clk_down;
							r.click_address = '0;
							if (len > 1) begin
								clk_active = 1'b1;
								clk_pos = 1;
							end
						end
						if (sched_mode == mcs_pkg::MODE_ARMED && countin_left > 0)
							countin_left = countin_left - 8'd1;
						beat_idx = 8'((int'(beat_idx) + 1) % int'(bar_beats));
						click_due_at = click_due_at + mcs_pkg::frame_t'(beat_len);
						lag = frame_now - click_due_at;
						if (at_or_after(frame_now, click_due_at) &&
						    lag > (mcs_pkg::frame_t'(1) << (mcs_pkg::FRAME_COUNT_BITS - 2)))
							click_due_at = frame_now;
					end
				end
				frame_now = frame_now + mcs_pkg::frame_t'(1);
			end
			default: ;
		endcase
		r.run_mode = sched_mode;
		r.count_in_left = countin_left;
		r.recorded_frames = take_frames;
		return r;
	endfunction

	task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fails++;
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------
	function automatic mcs_pkg::item_t any_beat(logic [1:0] cmd);
		mcs_pkg::item_t b;
		b.command = cmd;
		b.beat_interval = 20'($urandom);
		b.beats_per_bar = 8'($urandom);
		b.count_in_beats = 8'($urandom);
		b.pre_roll_frames = 20'($urandom);
		b.mic_sample = 16'($urandom);
		return b;
	endfunction

	function automatic mcs_pkg::item_t mk(logic [1:0] cmd, logic [19:0] iv, logic [7:0] bpb,
	                                      logic [7:0] ci, logic [19:0] pre,
	                                      logic signed [15:0] mic);
		mcs_pkg::item_t b;
		b.command = cmd;
		b.beat_interval = iv;
		b.beats_per_bar = bpb;
		b.count_in_beats = ci;
		b.pre_roll_frames = pre;
		b.mic_sample = mic;
		return b;
	endfunction

	// Arm with a grid that mostly clicks often and reaches the downbeat soon.
	function automatic mcs_pkg::item_t arm_beat();
		mcs_pkg::item_t b;
		b = any_beat(mcs_pkg::CMD_ARM);
		case ($urandom_range(7))
			0: b.beat_interval = '0;
			1, 2, 3, 4: b.beat_interval = 20'($urandom_range(1, 12));
			5: b.beat_interval = 20'($urandom_range(13, 300));
			default: ;
		endcase
		if ($urandom_range(3) != 0)
			b.count_in_beats = 8'($urandom_range(0, 4));
		if ($urandom_range(3) != 0)
			b.beats_per_bar = 8'($urandom_range(0, 6));
		if ($urandom_range(3) != 0)
			b.pre_roll_frames = 20'($urandom_range(0, 40));
		return b;
	endfunction

	task automatic push(mcs_pkg::item_t b);
		pending_beats.push_back(b);
		n_queued++;
	endtask

	task automatic push_ticks(int n);
		repeat (n) push(any_beat(mcs_pkg::CMD_TICK));
	endtask

	// One take: maybe a frame, arm, a run of frames with the odd stop, re-arm or unused code, maybe a stop.
	task automatic queue_session();
		int             n;
		mcs_pkg::item_t b;
		if ($urandom_range(9) == 0)
			push(any_beat(mcs_pkg::CMD_TICK));
		push(arm_beat());
		n = $urandom_range(4, 60);
		repeat (n) begin
			case ($urandom_range(99))
				0, 1: b = any_beat(mcs_pkg::CMD_STOP);
				2: b = any_beat(CMD_NONE);
				3: b = arm_beat();
				default: b = any_beat(mcs_pkg::CMD_TICK);
			endcase
			push(b);
		end
		if ($urandom_range(1) != 0)
			push(any_beat(mcs_pkg::CMD_STOP));
	endtask

	task automatic queue_sessions(int n);
		int goal;
		goal = n_queued + n;
		while (n_queued < goal)
			queue_session();
	endtask

	// Wait until every queued beat has been sent and answered.
	task automatic settle();
		while (!(n_sent == n_queued && due_results.size() == 0))
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Write click_length, then read it back.
	task automatic set_click_length(logic [11:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= mcs_pkg::PADDR_BITS'(4 * int'(mcs_pkg::REG_CLICK_LENGTH));
		pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tmpl_len = val;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("click_length readback", val, prdata[11:0]);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Sender: predict each accepted beat, then offer the next one or idle.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				due_results.push_back(schedule_item(cur_beat));
				n_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_beat = pending_beats.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {cur_beat.mic_sample, cur_beat.pre_roll_frames,
					                 cur_beat.count_in_beats, cur_beat.beats_per_bar,
					                 cur_beat.beat_interval};
					s_axis_tuser <= cur_beat.command;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: check each result beat against the oldest prediction,
	// then pick the next ready, with one long hold-off on request.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_results.size() == 0) begin
					$error("result beat with no input beat pending");
					fails++;
				end else begin
					want = due_results.pop_front();
					check_field("run_mode", want.run_mode, m_axis_tdata[1:0]);
					check_field("click_on", want.click_on, m_axis_tdata[2]);
					check_field("click_is_downbeat", want.click_is_downbeat, m_axis_tdata[3]);
					check_field("click_address", want.click_address, m_axis_tdata[15:4]);
					check_field("record_strobe", want.record_strobe, m_axis_tdata[16]);
					check_field("record_sample", $unsigned(want.record_sample),
					            m_axis_tdata[32:17]);
					check_field("count_in_left", want.count_in_left, m_axis_tdata[40:33]);
					check_field("recorded_frames", want.recorded_frames, m_axis_tdata[72:41]);
				end
			end
			if (long_hold_req && !long_hold_done) begin
				hold_left = LONG_HOLD;
				long_hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("metronome_click_scheduler regression: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence of the run
	// ------------------------------------------------------------------
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle mode: a frame with the most negative sample, the unused code, a stop.
		push(mk(mcs_pkg::CMD_TICK, '1, '1, '1, '1, 16'sh8000));
		push(mk(CMD_NONE, '1, '1, '1, '1, 16'sh7fff));
		push(mk(mcs_pkg::CMD_STOP, '0, '0, '0, '0, 16'sh0000));
		// Zero interval and bar clamped to one; a pre-roll reaching back past
		// frame zero makes the capture start wrap around the counter.
		push(mk(mcs_pkg::CMD_ARM, 20'd0, 8'd0, 8'd2, 20'd9, 16'sh0000));
		push_ticks(3);
		settle();

		// Beats every 4 frames against a 480 frame click: the next click waits
		// its turn. Then shorten the template under the running click so it
		// ends silently and the overdue beat sounds on that frame.
		push(mk(mcs_pkg::CMD_ARM, 20'd4, 8'd3, 8'd1, 20'd2, 16'sh0000));
		push_ticks(6);
		settle();
		set_click_length(12'd3);
		push_ticks(2);
		settle();

		// Zero length template: beats counted, nothing sounds.
		set_click_length(12'd0);
		push(mk(mcs_pkg::CMD_ARM, 20'd1, 8'd255, 8'd0, 20'd0, 16'sh0000));
		push_ticks(2);
		settle();
		set_click_length(12'd1);
		push_ticks(1);

		// Every arm field at its top value, then a stop in the middle of the count-in.
		push(mk(mcs_pkg::CMD_ARM, '1, '1, '1, '1, 16'sh7fff));
		push(mk(mcs_pkg::CMD_TICK, '0, '0, '0, '0, 16'sh7fff));
		push(mk(mcs_pkg::CMD_TICK, '0, '0, '0, '0, 16'sh8000));
		push(mk(mcs_pkg::CMD_STOP, '1, '1, '1, '1, 16'sh0000));
		push_ticks(1);
		settle();

		// Random takes: sender mostly busy, receiver mostly stalled.
		set_click_length(12'($urandom_range(2, 12)));
		send_idle_pct <= 7;
		recv_idle_pct <= 79;
		queue_sessions(300);
		settle();

		// Longest template, sender sparse, receiver eager.
		set_click_length(12'd4095);
		send_idle_pct <= 79;
		recv_idle_pct <= 7;
		queue_sessions(300);
		settle();

		// Full rate both ways, with one long receiver hold-off to back up the input.
		set_click_length(12'($urandom_range(1, 40)));
		send_idle_pct <= 0;
		recv_idle_pct <= 0;
		long_hold_req <= 1'b1;
		queue_sessions(300);
		settle();

		repeat (5) @(posedge clk);
		if (fails == 0 && due_results.size() == 0)
			$display("metronome_click_scheduler regression: pass");
		else
			$display("metronome_click_scheduler regression: fail");
		$finish;
	end

endmodule
